>>> sv/ggvt_pkg.sv
`timescale 1ns / 1ps

package ggvt_pkg;

  localparam int DIES   = 8;
  localparam int BLOCKS = 1024;
  localparam int PAGES  = 64;

  localparam int NB      = PAGES + 1;
  localparam int DIE_W   = 3;
  localparam int BLK_W   = 10;
  localparam int PG_W    = 6;
  localparam int CNT_W   = 7;
  localparam int MASK_W  = 64;
  localparam int WEAR_W  = 16;
  localparam int LINK_W  = $clog2(BLOCKS + 1);
  localparam int BLK_AW  = $clog2(DIES * BLOCKS);
  localparam int BKT_AW  = $clog2(DIES * NB);
  localparam int INFO_W  = WEAR_W + PAGES + CNT_W;

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(BLOCKS);
  localparam logic [WEAR_W-1:0] WEAR_MAX  = {WEAR_W{1'b1}};

  localparam logic       FUNC_INVALIDATE = 1'b0;
  localparam logic       FUNC_COLLECT    = 1'b1;

  localparam logic [1:0] ST_INVALIDATED = 2'd0;
  localparam logic [1:0] ST_IGNORED     = 2'd1;
  localparam logic [1:0] ST_VICTIM      = 2'd2;
  localparam logic [1:0] ST_NO_VICTIM   = 2'd3;

  typedef struct packed {
    logic              en;
    logic              set;
    logic [DIE_W-1:0]  die;
    logic [CNT_W-1:0]  bkt;
  } bmp_upd_t;

  function automatic logic [BLK_AW-1:0] blk_addr(input logic [DIE_W-1:0] d,
                                                 input logic [BLK_W-1:0] b);
    blk_addr = BLK_AW'(d) * BLK_AW'(BLOCKS) + BLK_AW'(b);
  endfunction

  function automatic logic [BKT_AW-1:0] bkt_addr(input logic [DIE_W-1:0] d,
                                                 input logic [CNT_W-1:0] c);
    bkt_addr = BKT_AW'(d) * BKT_AW'(NB) + BKT_AW'(c);
  endfunction

endpackage

>>> sv/ggvt_ram.sv
`timescale 1ns / 1ps

module ggvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ggvt_bitmap.sv
`timescale 1ns / 1ps

module ggvt_bitmap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ggvt_pkg::bmp_upd_t          upd_i,
  input  logic [ggvt_pkg::DIE_W-1:0]  die_i,
  output logic                        hit_o,
  output logic [ggvt_pkg::CNT_W-1:0]  top_o
);

  logic [ggvt_pkg::PAGES-1:0] ne_q [ggvt_pkg::DIES];
  logic [ggvt_pkg::PAGES-1:0] row;
  logic [ggvt_pkg::PG_W-1:0]  upd_pos;

  assign upd_pos = ggvt_pkg::PG_W'(upd_i.bkt - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ggvt_pkg::DIES; i++) begin
        ne_q[i] <= '0;
      end
    end else if (upd_i.en && upd_i.bkt != '0) begin
      ne_q[upd_i.die][upd_pos] <= upd_i.set;
    end
  end

  assign row = ne_q[die_i];

  always_comb begin
    top_o = '0;
    for (int i = 0; i < ggvt_pkg::PAGES; i++) begin
      if (row[i]) begin
        top_o = ggvt_pkg::CNT_W'(i + 1);
      end
    end
  end

  assign hit_o = |row;

endmodule

>>> sv/greedy_gc_victim_tracker.sv
`timescale 1ns / 1ps

// Greedy garbage-collection victim tracker for a multi-die flash array.
// The input channel takes one beat per item: func_i selects invalidating one
// page (die, block, page) or collecting a victim block of a die. Every item
// gives exactly one beat on the output channel with the status and fields.
// An invalidate item steps through reading the block tables, unlinking the
// block from its bucket, linking it into the next bucket and a final step;
// a collect item through selecting the bucket, reading its head and a final
// step. An ignored invalidate ends at the unlink step, a collect with no
// victim at the select step. The input is ready again in the same cycle as
// the result appears; one item is worked on at a time, and the steps follow
// the reads of the block and bucket tables, each a synchronous memory.
// The output beat sits in a register, so the next item is accepted while a
// result still waits; if the receiver stalls and a second result is ready,
// the sequencer holds in its last step until the register frees up.
// After reset the block runs a clearing pass over all 8192 block entries
// (and the 520 bucket entries in the same sweep), during which in_ready_o
// stays low. The spare block of every die starts as the last block of the die.

module greedy_gc_victim_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         func_i,
  input  logic [2:0]   die_index_i,
  input  logic [9:0]   block_number_i,
  input  logic [5:0]   page_in_block_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   status_o,
  output logic [9:0]   victim_block_o,
  output logic [63:0]  copy_mask_o,
  output logic [6:0]   victim_invalid_count_o,
  output logic [9:0]   active_block_o,
  output logic [6:0]   new_invalid_count_o
);

  localparam int CNT_W  = ggvt_pkg::CNT_W;
  localparam int LINK_W = ggvt_pkg::LINK_W;
  localparam int BLK_W  = ggvt_pkg::BLK_W;
  localparam int BLK_AW = ggvt_pkg::BLK_AW;
  localparam int BKT_AW = ggvt_pkg::BKT_AW;
  localparam int INFO_W = ggvt_pkg::INFO_W;
  localparam int PAGES  = ggvt_pkg::PAGES;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_I_RD  = 4'd2;
  localparam logic [3:0] S_I_UNL = 4'd3;
  localparam logic [3:0] S_I_LNK = 4'd4;
  localparam logic [3:0] S_I_FIN = 4'd5;
  localparam logic [3:0] S_C_SEL = 4'd6;
  localparam logic [3:0] S_C_HD  = 4'd7;
  localparam logic [3:0] S_C_FIN = 4'd8;

  localparam logic [BLK_AW-1:0] CLR_LAST = BLK_AW'(ggvt_pkg::DIES * ggvt_pkg::BLOCKS - 1);

  logic [3:0]        state_q, state_d;
  logic [BLK_AW-1:0] clr_q, clr_d;
  logic              func_q;
  logic [2:0]        d_q;
  logic [9:0]        b_q;
  logic [5:0]        pg_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [BLK_W-1:0]  v_q, v_d;
  logic [BLK_W-1:0]  spare_q [ggvt_pkg::DIES];
  logic              spare_we;

  logic              ov_q, ov_d;
  logic [1:0]        st_q, st_d;
  logic [9:0]        vb_q, vb_d;
  logic [63:0]       cm_q, cm_d;
  logic [6:0]        vic_q, vic_d;
  logic [9:0]        ab_q, ab_d;
  logic [6:0]        nic_q, nic_d;

  logic              info_we, prev_we, next_we, head_we, tail_we;
  logic [BLK_AW-1:0] info_wa, prev_wa, next_wa, blk_ra;
  logic [BKT_AW-1:0] head_wa, tail_wa, head_ra, tail_ra;
  logic [INFO_W-1:0] info_wd, info_rd;
  logic [LINK_W-1:0] prev_wd, next_wd, head_wd, tail_wd;
  logic [LINK_W-1:0] prev_rd, next_rd, head_rd, tail_rd;

  logic [CNT_W-1:0]       rd_cnt;
  logic [PAGES-1:0]       rd_val;
  logic [ggvt_pkg::WEAR_W-1:0] rd_wear, wear_inc;
  logic                   bad_addr, already, can_out, accept;
  ggvt_pkg::bmp_upd_t     bmp_upd;
  logic                   bmp_hit;
  logic [CNT_W-1:0]       bmp_top;
  logic [PAGES-1:0]       reset_val;

  assign reset_val = {PAGES{1'b1}};
  assign rd_cnt  = info_rd[CNT_W-1:0];
  assign rd_val  = info_rd[CNT_W +: PAGES];
  assign rd_wear = info_rd[CNT_W + PAGES +: ggvt_pkg::WEAR_W];
  assign wear_inc = (rd_wear != ggvt_pkg::WEAR_MAX) ? rd_wear + 1'b1 : rd_wear;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_out    = !ov_q || out_ready_i;

  assign bad_addr = (int'(d_q) >= ggvt_pkg::DIES) || (int'(b_q) >= ggvt_pkg::BLOCKS) ||
                    (int'(pg_q) >= PAGES);
  assign already  = !rd_val[pg_q] || (int'(rd_cnt) >= PAGES);

  always_comb begin
    if (state_q == S_C_HD) begin
      blk_ra = ggvt_pkg::blk_addr(d_q, head_rd[BLK_W-1:0]);
    end else if (func_q == ggvt_pkg::FUNC_COLLECT) begin
      blk_ra = ggvt_pkg::blk_addr(d_q, v_q);
    end else begin
      blk_ra = ggvt_pkg::blk_addr(d_q, b_q);
    end
  end

  assign head_ra = ggvt_pkg::bkt_addr(d_q, bmp_top);
  assign tail_ra = ggvt_pkg::bkt_addr(d_q, rd_cnt + 1'b1);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    v_d     = v_q;
    spare_we = 1'b0;
    ov_d  = ov_q && !out_ready_i;
    st_d  = st_q;
    vb_d  = vb_q;
    cm_d  = cm_q;
    vic_d = vic_q;
    ab_d  = ab_q;
    nic_d = nic_q;
    info_we = 1'b0; prev_we = 1'b0; next_we = 1'b0; head_we = 1'b0; tail_we = 1'b0;
    info_wa = blk_ra; prev_wa = blk_ra; next_wa = blk_ra;
    head_wa = ggvt_pkg::bkt_addr(d_q, cnt_q);
    tail_wa = ggvt_pkg::bkt_addr(d_q, cnt_q);
    info_wd = {rd_wear, rd_val, rd_cnt};
    prev_wd = ggvt_pkg::NONE_LINK;
    next_wd = ggvt_pkg::NONE_LINK;
    head_wd = ggvt_pkg::NONE_LINK;
    tail_wd = ggvt_pkg::NONE_LINK;
    bmp_upd = '0;

    case (state_q)
      S_CLR: begin
        info_we = 1'b1; prev_we = 1'b1; next_we = 1'b1;
        info_wa = clr_q; prev_wa = clr_q; next_wa = clr_q;
        info_wd = {{ggvt_pkg::WEAR_W{1'b0}}, reset_val, {CNT_W{1'b0}}};
        if (int'(clr_q) < ggvt_pkg::DIES * ggvt_pkg::NB) begin
          head_we = 1'b1; tail_we = 1'b1;
          head_wa = clr_q[BKT_AW-1:0];
          tail_wa = clr_q[BKT_AW-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (func_i == ggvt_pkg::FUNC_COLLECT) ? S_C_SEL : S_I_RD;
        end
      end
      S_I_RD: begin
        state_d = S_I_UNL;
      end
      S_I_UNL: begin
        if (bad_addr || already) begin
          if (can_out) begin
            ov_d = 1'b1; st_d = ggvt_pkg::ST_IGNORED;
            vb_d = '0; cm_d = '0; vic_d = '0; ab_d = '0;
            nic_d = bad_addr ? 7'd0 : 7'(rd_cnt);
            state_d = S_IDLE;
          end
        end else begin
          cnt_d = rd_cnt + 1'b1;
          if (rd_cnt != '0) begin
            if (prev_rd != ggvt_pkg::NONE_LINK) begin
              next_we = 1'b1;
              next_wa = ggvt_pkg::blk_addr(d_q, prev_rd[BLK_W-1:0]);
              next_wd = next_rd;
            end else begin
              head_we = 1'b1;
              head_wa = ggvt_pkg::bkt_addr(d_q, rd_cnt);
              head_wd = next_rd;
            end
            if (next_rd != ggvt_pkg::NONE_LINK) begin
              prev_we = 1'b1;
              prev_wa = ggvt_pkg::blk_addr(d_q, next_rd[BLK_W-1:0]);
              prev_wd = prev_rd;
            end else begin
              tail_we = 1'b1;
              tail_wa = ggvt_pkg::bkt_addr(d_q, rd_cnt);
              tail_wd = prev_rd;
            end
            if (prev_rd == ggvt_pkg::NONE_LINK && next_rd == ggvt_pkg::NONE_LINK) begin
              bmp_upd = '{en: 1'b1, set: 1'b0, die: d_q, bkt: rd_cnt};
            end
          end
          info_we = 1'b1;
          info_wd = {rd_wear, rd_val & ~(PAGES'(1) << pg_q), rd_cnt + 1'b1};
          state_d = S_I_LNK;
        end
      end
      S_I_LNK: begin
        prev_we = 1'b1;
        prev_wd = tail_rd;
        if (tail_rd != ggvt_pkg::NONE_LINK) begin
          next_we = 1'b1;
          next_wa = ggvt_pkg::blk_addr(d_q, tail_rd[BLK_W-1:0]);
          next_wd = LINK_W'(b_q);
        end else begin
          head_we = 1'b1;
          head_wd = LINK_W'(b_q);
        end
        tail_we = 1'b1;
        tail_wd = LINK_W'(b_q);
        bmp_upd = '{en: 1'b1, set: 1'b1, die: d_q, bkt: cnt_q};
        state_d = S_I_FIN;
      end
      S_I_FIN: begin
        next_we = 1'b1;
        if (can_out) begin
          ov_d = 1'b1; st_d = ggvt_pkg::ST_INVALIDATED;
          vb_d = '0; cm_d = '0; vic_d = '0; ab_d = '0;
          nic_d = 7'(cnt_q);
          state_d = S_IDLE;
        end
      end
      S_C_SEL: begin
        if ((int'(d_q) >= ggvt_pkg::DIES) || !bmp_hit) begin
          if (can_out) begin
            ov_d = 1'b1; st_d = ggvt_pkg::ST_NO_VICTIM;
            vb_d = '0; cm_d = '0; vic_d = '0; ab_d = '0; nic_d = '0;
            state_d = S_IDLE;
          end
        end else begin
          cnt_d = bmp_top;
          state_d = S_C_HD;
        end
      end
      S_C_HD: begin
        v_d = head_rd[BLK_W-1:0];
        state_d = S_C_FIN;
      end
      S_C_FIN: begin
        if (can_out) begin
          head_we = 1'b1;
          head_wd = next_rd;
          if (next_rd != ggvt_pkg::NONE_LINK) begin
            prev_we = 1'b1;
            prev_wa = ggvt_pkg::blk_addr(d_q, next_rd[BLK_W-1:0]);
          end else begin
            tail_we = 1'b1;
            bmp_upd = '{en: 1'b1, set: 1'b0, die: d_q, bkt: cnt_q};
          end
          info_we = 1'b1;
          info_wd = {wear_inc, reset_val, {CNT_W{1'b0}}};
          next_we = 1'b1;
          spare_we = 1'b1;
          ov_d = 1'b1; st_d = ggvt_pkg::ST_VICTIM;
          vb_d = v_q;
          cm_d = 64'(rd_val);
          vic_d = 7'(rd_cnt);
          ab_d = spare_q[d_q];
          nic_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < ggvt_pkg::DIES; i++) begin
        spare_q[i] <= BLK_W'(ggvt_pkg::BLOCKS - 1);
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      if (spare_we) begin
        spare_q[d_q] <= v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      d_q    <= die_index_i;
      b_q    <= block_number_i;
      pg_q   <= page_in_block_i;
    end
    cnt_q <= cnt_d;
    v_q   <= v_d;
    st_q  <= st_d;
    vb_q  <= vb_d;
    cm_q  <= cm_d;
    vic_q <= vic_d;
    ab_q  <= ab_d;
    nic_q <= nic_d;
  end

  ggvt_ram #(.WIDTH(INFO_W), .DEPTH(ggvt_pkg::DIES * ggvt_pkg::BLOCKS)) u_info (
    .clk_i, .we_i(info_we), .waddr_i(info_wa), .wdata_i(info_wd),
    .raddr_i(blk_ra), .rdata_o(info_rd)
  );

  ggvt_ram #(.WIDTH(LINK_W), .DEPTH(ggvt_pkg::DIES * ggvt_pkg::BLOCKS)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(blk_ra), .rdata_o(prev_rd)
  );

  ggvt_ram #(.WIDTH(LINK_W), .DEPTH(ggvt_pkg::DIES * ggvt_pkg::BLOCKS)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(blk_ra), .rdata_o(next_rd)
  );

  ggvt_ram #(.WIDTH(LINK_W), .DEPTH(ggvt_pkg::DIES * ggvt_pkg::NB)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd)
  );

  ggvt_ram #(.WIDTH(LINK_W), .DEPTH(ggvt_pkg::DIES * ggvt_pkg::NB)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_wa), .wdata_i(tail_wd),
    .raddr_i(tail_ra), .rdata_o(tail_rd)
  );

  ggvt_bitmap u_bitmap (
    .clk_i, .rst_ni, .upd_i(bmp_upd), .die_i(d_q), .hit_o(bmp_hit), .top_o(bmp_top)
  );

  assign out_valid_o            = ov_q;
  assign status_o               = st_q;
  assign victim_block_o         = vb_q;
  assign copy_mask_o            = cm_q;
  assign victim_invalid_count_o = vic_q;
  assign active_block_o         = ab_q;
  assign new_invalid_count_o    = nic_q;

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !out_valid_o)
    else $error("Result shown during the clearing pass.");

  a_victim_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ggvt_pkg::ST_VICTIM |->
      new_invalid_count_o == 7'd0 && victim_invalid_count_o != 7'd0)
    else $error("Victim beat carries inconsistent counts.");

  a_invalidated_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ggvt_pkg::ST_INVALIDATED |-> new_invalid_count_o != 7'd0)
    else $error("Invalidated beat with a zero count.");

  a_link_follows_unlink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_I_LNK |=> state_q == S_I_FIN)
    else $error("Bucket append did not complete.");

endmodule
